// ===== design/cnf_pkg.sv =====
// Shared constants, types and helpers for the correlated noise FIR core.
package cnf_pkg;

    localparam int TAPS      = 64;
    localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W     = $clog2(TAPS + 1);
    localparam int CFG_W     = 7;
    localparam int IDX_W     = 6;
    localparam int SMP_W     = 16;
    localparam int OUT_W     = 24;
    localparam int FRAC_BITS = 12;
    localparam int PROD_W    = 2 * SMP_W;
    localparam int ACC_W     = PROD_W + CNT_W + 1;

    localparam logic [CFG_W-1:0] ACTIVE_TAPS_RST = CFG_W'(64);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [OUT_W-1:0]  t_out;

    typedef struct packed {
        logic clr;
        logic en;
        logic hist_vld;
        logic coef_vld;
    } t_mac_ctl;

    // Clamp the programmed tap count into 1..TAPS.
    function automatic logic [CNT_W-1:0] eff_taps(input logic [CFG_W-1:0] a);
        if (a == '0) begin
            return CNT_W'(1);
        end else if (int'(a) > TAPS) begin
            return CNT_W'(TAPS);
        end else begin
            return CNT_W'(a);
        end
    endfunction

endpackage

// ===== design/cnf_if.sv =====
// Handshake channel interfaces for the correlated noise FIR core.
interface cnf_in_if;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [cnf_pkg::IDX_W-1:0] coef_index;
    cnf_pkg::t_smp            coef_value;
    cnf_pkg::t_smp            sample;

    modport source (output valid, func, coef_index, coef_value, sample, input ready);
    modport sink   (input valid, func, coef_index, coef_value, sample, output ready);
endinterface

interface cnf_out_if;
    logic          valid;
    logic          ready;
    cnf_pkg::t_out correlated;

    modport source (output valid, correlated, input ready);
    modport sink   (input valid, correlated, output ready);
endinterface

interface cnf_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cnf_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/cnf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cnf_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cnf_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulate.
module cnf_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cnf_pkg::t_mac_ctl i_ctl,
    input  cnf_pkg::t_smp     i_hist,
    input  cnf_pkg::t_smp     i_coef,
    output cnf_pkg::t_acc     o_acc,
    output logic              o_busy
);

    logic           r_pv;
    cnf_pkg::t_prod r_prod;
    cnf_pkg::t_prod n_prod;
    cnf_pkg::t_acc  r_acc;

    // Entries never written read as zero.
    always_comb begin
        if (i_ctl.hist_vld && i_ctl.coef_vld) begin
            n_prod = cnf_pkg::t_prod'(i_hist) * cnf_pkg::t_prod'(i_coef);
        end else begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.en;
        end
        r_prod <= n_prod;
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + cnf_pkg::t_acc'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_pv;

endmodule

// ===== design/correlated_noise_fir_core.sv =====
// Top level of the correlated noise FIR core: sequencer, history and coefficient stores.
//
//  channel  | dir | payload                              | accepted when
//  ---------+-----+--------------------------------------+----------------------
//  i_cfg    | in  | data (active_taps, 7 bits)           | valid && ready
//  i_smp    | in  | func, coef_index, coef_value, sample | valid && ready
//  o_res    | out | correlated (24 bits, signed Q24.0)   | valid && ready
//
// A load is taken while idle and leaves ready high. A sample keeps ready low from its
// acceptance (n = clamped tap count): n tap reads, then the RAM read, the product
// register and the accumulator drain; the result is valid after that.
// Synchronous active-low reset; stores read as zero until written (valid bits).
// A finished result waits in the output register; a further sample stalls in
// its final cycle only while that register is still full.
module correlated_noise_fir_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cnf_cfg_if.sink   i_cfg,
    cnf_in_if.sink    i_smp,
    cnf_out_if.source o_res
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} t_state_e;

    localparam cnf_pkg::t_acc SAT_HI = cnf_pkg::t_acc'((1 <<< (cnf_pkg::OUT_W - 1)) - 1);
    localparam cnf_pkg::t_acc SAT_LO = cnf_pkg::t_acc'(-(1 <<< (cnf_pkg::OUT_W - 1)));

    t_state_e                      r_state;
    logic [cnf_pkg::CFG_W-1:0]     r_active_taps;
    logic [cnf_pkg::TAP_W-1:0]     r_newest;
    logic [cnf_pkg::CNT_W-1:0]     r_n;
    logic [cnf_pkg::TAP_W-1:0]     r_i;
    logic [cnf_pkg::TAP_W-1:0]     r_j;
    logic [cnf_pkg::TAPS-1:0]      r_hvld;
    logic [cnf_pkg::TAPS-1:0]      r_cvld;
    logic                          r_rd_v;
    logic                          r_hv_rd;
    logic                          r_cv_rd;
    logic                          r_out_valid;
    cnf_pkg::t_out                 r_out;

    logic                          smp_acc;
    logic                          is_load;
    logic                          load_ok;
    logic [cnf_pkg::TAP_W-1:0]     load_idx;
    logic [cnf_pkg::CNT_W-1:0]     eff;
    logic [cnf_pkg::CNT_W-1:0]     slot_inc;
    logic [cnf_pkg::TAP_W-1:0]     n_slot;
    logic [cnf_pkg::TAP_W-1:0]     n_j;
    logic                          last_tap;
    logic                          out_free;
    logic                          done;
    logic [cnf_pkg::SMP_W-1:0]     hist_rd;
    logic [cnf_pkg::SMP_W-1:0]     coef_rd;
    cnf_pkg::t_mac_ctl             mac_ctl;
    cnf_pkg::t_acc                 mac_acc;
    logic                          mac_busy;
    cnf_pkg::t_acc                 shifted;
    cnf_pkg::t_out                 sat_val;

    assign i_cfg.ready = 1'b1;
    assign i_smp.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.correlated = r_out;

    assign smp_acc  = i_smp.valid && i_smp.ready;
    assign is_load  = (i_smp.func == cnf_pkg::FUNC_LOAD);
    assign load_ok  = int'(i_smp.coef_index) < cnf_pkg::TAPS;
    assign load_idx = cnf_pkg::TAP_W'(i_smp.coef_index);

    assign eff      = cnf_pkg::eff_taps(r_active_taps);
    assign slot_inc = cnf_pkg::CNT_W'(r_newest) + cnf_pkg::CNT_W'(1);
    assign n_slot   = (slot_inc >= eff) ? '0 : cnf_pkg::TAP_W'(slot_inc);

    // Walk the history backward, wrapping at the tap count.
    assign n_j      = (r_j == '0) ? cnf_pkg::TAP_W'(r_n - cnf_pkg::CNT_W'(1))
                                  : r_j - cnf_pkg::TAP_W'(1);
    assign last_tap = (cnf_pkg::CNT_W'(r_i) == r_n - cnf_pkg::CNT_W'(1));

    assign out_free = !r_out_valid || o_res.ready;
    assign done     = (r_state == S_DRAIN) && !r_rd_v && !mac_busy && out_free;

    // Floor shift, then clamp to the output range.
    always_comb begin
        shifted = mac_acc >>> cnf_pkg::FRAC_BITS;
        priority if (shifted > SAT_HI) begin
            sat_val = cnf_pkg::t_out'(SAT_HI);
        end else if (shifted < SAT_LO) begin
            sat_val = cnf_pkg::t_out'(SAT_LO);
        end else begin
            sat_val = cnf_pkg::t_out'(shifted);
        end
    end

    assign mac_ctl.clr      = smp_acc && !is_load;
    assign mac_ctl.en       = r_rd_v;
    assign mac_ctl.hist_vld = r_hv_rd;
    assign mac_ctl.coef_vld = r_cv_rd;

    cnf_ram #(
        .WIDTH (cnf_pkg::SMP_W),
        .DEPTH (cnf_pkg::TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (smp_acc && !is_load),
        .i_waddr (n_slot),
        .i_wdata (i_smp.sample),
        .i_raddr (r_j),
        .o_rdata (hist_rd)
    );

    cnf_ram #(
        .WIDTH (cnf_pkg::SMP_W),
        .DEPTH (cnf_pkg::TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (smp_acc && is_load && load_ok),
        .i_waddr (load_idx),
        .i_wdata (i_smp.coef_value),
        .i_raddr (r_i),
        .o_rdata (coef_rd)
    );

    cnf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_hist  (cnf_pkg::t_smp'(hist_rd)),
        .i_coef  (cnf_pkg::t_smp'(coef_rd)),
        .o_acc   (mac_acc),
        .o_busy  (mac_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_active_taps <= cnf_pkg::ACTIVE_TAPS_RST;
            r_newest      <= '0;
            r_hvld        <= '0;
            r_cvld        <= '0;
            r_rd_v        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_active_taps <= i_cfg.data;
            end
            if (o_res.valid && o_res.ready && !done) begin
                r_out_valid <= 1'b0;
            end
            r_rd_v <= (r_state == S_RUN);
            unique case (r_state)
                S_IDLE: begin
                    if (smp_acc) begin
                        if (is_load) begin
                            if (load_ok) begin
                                r_cvld[load_idx] <= 1'b1;
                            end
                        end else begin
                            r_newest       <= n_slot;
                            r_hvld[n_slot] <= 1'b1;
                            r_n            <= eff;
                            r_i            <= '0;
                            r_j            <= n_slot;
                            r_state        <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_hv_rd <= r_hvld[r_j];
                    r_cv_rd <= r_cvld[r_i];
                    if (last_tap) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_i <= r_i + cnf_pkg::TAP_W'(1);
                        r_j <= n_j;
                    end
                end
                S_DRAIN: begin
                    // Hold until the pipeline empties and the output slot is free.
                    if (done) begin
                        r_out       <= sat_val;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_run_i_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (cnf_pkg::CNT_W'(r_i) < r_n))
        else $error("tap counter beyond tap count");

    a_run_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (cnf_pkg::CNT_W'(r_j) < r_n))
        else $error("history pointer beyond tap count");

    a_drain_no_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> !r_rd_v)
        else $error("read issued after last tap");

    a_out_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DRAIN))
        else $error("result raised outside drain");

endmodule

// ===== test/correlated_noise_fir_core_test.sv =====
// Testbench for the correlated noise FIR core: directed and random requests, self-checked.
`timescale 1ns / 100ps

module correlated_noise_fir_core_test;

    localparam int            LIMIT_CYCLES = 1_000_000;
    localparam int            HOLD_CYCLES  = 600;
    localparam int            ITEM_TARGET  = 1750;
    localparam int            SETTLE       = cnf_pkg::TAPS + 8;
    localparam cnf_pkg::t_smp SMP_MAX      = 16'sh7fff;
    localparam cnf_pkg::t_smp SMP_MIN      = 16'sh8000;
    localparam longint        SAT_HI       = (longint'(1) <<< (cnf_pkg::OUT_W - 1)) - 1;
    localparam longint        SAT_LO       = -(longint'(1) <<< (cnf_pkg::OUT_W - 1));

    logic i_clk;
    logic i_rst_n;

    cnf_cfg_if cfg_ch ();
    cnf_in_if  smp_ch ();
    cnf_out_if res_ch ();

    correlated_noise_fir_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_smp   (smp_ch),
        .o_res   (res_ch)
    );

    // Filter model state
    cnf_pkg::t_smp             hist_mem [cnf_pkg::TAPS];
    cnf_pkg::t_smp             coef_mem [cnf_pkg::TAPS];
    int unsigned               head_slot;
    logic [cnf_pkg::CFG_W-1:0] tap_reg;
    cnf_pkg::t_out             noise_due [$];

    int errors     = 0;
    int items_sent = 0;
    int cycles     = 0;
    bit steady     = 1'b0;
    int hold_reqs  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("FAIL correlated_noise_fir_core");
            $finish;
        end
    end

    // Advance the history, then sum coefficient i times the sample i steps back.
    function automatic cnf_pkg::t_out filter_sample(input cnf_pkg::t_smp s);
        int unsigned n;
        int unsigned j;
        longint      acc;
        n = (tap_reg == '0) ? 1 :
            ((int'(tap_reg) > cnf_pkg::TAPS) ? cnf_pkg::TAPS : int'(tap_reg));
        head_slot = (head_slot + 1 >= n) ? 0 : head_slot + 1;
        hist_mem[head_slot] = s;
        acc = 0;
        j = head_slot;
        for (int i = 0; i < n; i++) begin
            acc += longint'(hist_mem[j]) * longint'(coef_mem[i]);
            j = (j == 0) ? n - 1 : j - 1;
        end
        acc = acc >>> cnf_pkg::FRAC_BITS;
        if (acc > SAT_HI) begin
            acc = SAT_HI;
        end
        if (acc < SAT_LO) begin
            acc = SAT_LO;
        end
        return cnf_pkg::t_out'(acc);
    endfunction

    always @(posedge i_clk) begin : watch_channels
        cnf_pkg::t_out want;
        if (!i_rst_n) begin
            foreach (hist_mem[k]) begin
                hist_mem[k] = '0;
                coef_mem[k] = '0;
            end
            head_slot = 0;
            tap_reg = cnf_pkg::ACTIVE_TAPS_RST;
            noise_due.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (noise_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result: correlated=%0d", res_ch.correlated);
                    end
                end else begin
                    want = noise_due.pop_front();
                    if (res_ch.correlated !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: correlated expected %0d, got %0d",
                                     want, res_ch.correlated);
                        end
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                tap_reg = cfg_ch.data;
            end
            if (smp_ch.valid && smp_ch.ready) begin
                if (smp_ch.func == cnf_pkg::FUNC_LOAD) begin
                    coef_mem[smp_ch.coef_index] = smp_ch.coef_value;
                end else begin
                    noise_due.push_back(filter_sample(smp_ch.sample));
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen    <= hold_reqs;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= steady || ($urandom_range(99) >= 25);
        end
    end

    function automatic cnf_pkg::t_smp pick_value();
        case ($urandom_range(7))
            0:       return SMP_MIN;
            1:       return SMP_MAX;
            default: return cnf_pkg::t_smp'($urandom);
        endcase
    endfunction

    function automatic cnf_pkg::t_smp pick_loud(input bit polarity);
        if ($urandom_range(9) == 0) begin
            return pick_value();
        end
        return polarity ? SMP_MAX : SMP_MIN;
    endfunction

    function automatic logic [cnf_pkg::CFG_W-1:0] pick_taps();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return cnf_pkg::CFG_W'($urandom_range(8, 1));
        end
        if (r < 82) begin
            return cnf_pkg::CFG_W'($urandom_range(63, 9));
        end
        case ($urandom_range(3))
            0:       return '0;
            1:       return cnf_pkg::CFG_W'(cnf_pkg::TAPS);
            2:       return cnf_pkg::CFG_W'($urandom_range(126, 65));
            default: return '1;
        endcase
    endfunction

    task automatic push_item(input logic fn, input logic [cnf_pkg::IDX_W-1:0] idx,
                             input cnf_pkg::t_smp cv, input cnf_pkg::t_smp sv);
        if (!steady && $urandom_range(99) < 25) begin
            smp_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        smp_ch.valid      <= 1'b1;
        smp_ch.func       <= fn;
        smp_ch.coef_index <= idx;
        smp_ch.coef_value <= cv;
        smp_ch.sample     <= sv;
        do @(posedge i_clk); while (!smp_ch.ready);
        items_sent++;
    endtask

    task automatic load_coef(input int idx, input cnf_pkg::t_smp v);
        push_item(cnf_pkg::FUNC_LOAD, cnf_pkg::IDX_W'(idx), v, cnf_pkg::t_smp'($urandom));
    endtask

    task automatic push_sample(input cnf_pkg::t_smp v);
        push_item(cnf_pkg::FUNC_SAMPLE, cnf_pkg::IDX_W'($urandom),
                  cnf_pkg::t_smp'($urandom), v);
    endtask

    // Drop the request line and let every pending result drain.
    task automatic wait_idle();
        smp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (noise_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_taps(input logic [cnf_pkg::CFG_W-1:0] v);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample(pick_value());
    endtask

    task automatic test_extremes();
        load_coef(0, SMP_MIN);
        load_coef(cnf_pkg::TAPS - 1, SMP_MAX);
        load_coef(1, 16'sd1);
        push_sample(SMP_MIN);
        push_sample(SMP_MAX);
        push_sample(-16'sd1);
        // Single tap: check flooring of negative sums
        set_taps(cnf_pkg::CFG_W'(1));
        load_coef(0, 16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd1);
    endtask

    task automatic test_tap_edges();
        set_taps('0);
        load_coef(0, SMP_MAX);
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        set_taps('1);
        push_sample(pick_value());
        push_sample(pick_value());
        set_taps(cnf_pkg::CFG_W'(cnf_pkg::TAPS + 1));
        push_sample(pick_value());
        // Shrink below the newest slot so it wraps back to zero
        set_taps(cnf_pkg::CFG_W'(2));
        push_sample(pick_value());
        push_sample(pick_value());
    endtask

    task automatic test_backpressure();
        set_taps(cnf_pkg::CFG_W'(4));
        steady = 1'b1;
        hold_reqs <= hold_reqs + 1;
        repeat (12) push_sample(pick_value());
        steady = 1'b0;
    endtask

    task automatic test_random();
        int                        phase;
        int                        n;
        int                        count;
        bit                        loud;
        bit                        coef_pol;
        bit                        smp_pol;
        logic [cnf_pkg::CFG_W-1:0] taps;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            taps = pick_taps();
            set_taps(taps);
            steady = (phase >= 6 && phase <= 9);
            n = (taps == '0) ? 1 :
                ((int'(taps) > cnf_pkg::TAPS) ? cnf_pkg::TAPS : int'(taps));
            loud = ($urandom_range(3) == 0);
            coef_pol = 1'($urandom_range(1));
            smp_pol = 1'($urandom_range(1));
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9) != 0) begin
                    load_coef(i, loud ? pick_loud(coef_pol) : pick_value());
                end
            end
            count = int'($urandom_range(40, 10));
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(99) < 8) begin
                    load_coef(int'($urandom_range(cnf_pkg::TAPS - 1)), pick_value());
                end else if (loud) begin
                    if ($urandom_range(15) == 0) begin
                        smp_pol = !smp_pol;
                    end
                    push_sample(pick_loud(smp_pol));
                end else begin
                    push_sample(pick_value());
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        smp_ch.valid      <= 1'b0;
        smp_ch.func       <= cnf_pkg::FUNC_LOAD;
        smp_ch.coef_index <= '0;
        smp_ch.coef_value <= '0;
        smp_ch.sample     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_extremes();
        test_tap_edges();
        test_backpressure();
        test_random();

        wait_idle();
        errors += noise_due.size();
        if (errors == 0) begin
            $display("PASS correlated_noise_fir_core");
        end else begin
            $display("FAIL correlated_noise_fir_core");
        end
        $finish;
    end

endmodule
